[design/spd_pkg.sv]
package spd_pkg;

	// header characters
	localparam logic [7:0] HDR_S = 8'h73;
	localparam logic [7:0] HDR_N = 8'h6E;
	localparam logic [7:0] HDR_P = 8'h70;

	// buffers shorter than this report too short
	localparam logic [2:0] MIN_BUF_BYTES = 3'd7;

	// status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
	localparam logic [2:0] ST_NO_HEADER  = 3'd2;
	localparam logic [2:0] ST_INCOMPLETE = 3'd3;
	localparam logic [2:0] ST_BAD_SUM    = 3'd4;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_PAYLOAD,
		PH_TRAIL_HI,
		PH_TRAIL_LO
	} phase_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload_byte;
		logic [5:0] byte_index;
		logic [2:0] status;
		logic [7:0] packet_address;
		logic [7:0] packet_type;
		logic [5:0] payload_length;
		logic       last;
	} result_t;

	// payload length from the packet type byte
	function automatic logic [5:0] length_of_type(input logic [7:0] t);
		logic [5:0] len;
		if (!t[7]) begin
			len = 6'd0;
		end else if (!t[6]) begin
			len = 6'd4;
		end else begin
			len = {t[5:2], 2'b00};
		end
		return len;
	endfunction

endpackage

[design/spd_rx_if.sv]
interface spd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_buffer;

	modport source (output valid, output rx_byte, output end_of_buffer, input ready);
	modport sink (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

[design/spd_res_if.sv]
interface spd_res_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] payload_byte;
	logic [5:0] byte_index;
	logic [2:0] status;
	logic [7:0] packet_address;
	logic [7:0] packet_type;
	logic [5:0] payload_length;
	logic       last;

	modport source (output valid, output kind, output payload_byte, output byte_index,
		output status, output packet_address, output packet_type, output payload_length,
		output last, input ready);
	modport sink (input valid, input kind, input payload_byte, input byte_index,
		input status, input packet_address, input packet_type, input payload_length,
		input last, output ready);
endinterface

[design/spd_parse_core.sv]
module spd_parse_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [7:0]           cur_byte,
	input  logic                 cur_eob,
	input  logic [7:0]           requested_address,
	output logic                 res_valid,
	output spd_pkg::result_t     res
);

	logic [7:0]      window_q [4];
	spd_pkg::phase_t phase_q;
	logic [5:0]      count_q;
	logic [5:0]      total_q;
	logic [7:0]      type_q;
	logic [7:0]      addr_q;
	logic [15:0]     sum_q;
	logic [7:0]      trail_hi_q;
	logic [2:0]      bcount_q;
	logic            reported_q;

	logic [7:0]      window_d [4];
	spd_pkg::phase_t phase_d;
	logic [5:0]      count_d;
	logic [5:0]      total_d;
	logic [7:0]      type_d;
	logic [7:0]      addr_d;
	logic [15:0]     sum_d;
	logic [7:0]      trail_hi_d;
	logic [2:0]      bcount_d;
	logic            reported_d;

	logic [5:0]      count_inc;
	logic            hdr_hit;

	assign count_inc = count_q + 6'd1;
	assign hdr_hit = (window_q[0] == spd_pkg::HDR_S) && (window_q[1] == spd_pkg::HDR_N)
		&& (window_q[2] == spd_pkg::HDR_P)
		&& ((requested_address == 8'd0) || (cur_byte == requested_address));

	always_comb begin
		window_d   = window_q;
		phase_d    = phase_q;
		count_d    = count_q;
		total_d    = total_q;
		type_d     = type_q;
		addr_d     = addr_q;
		sum_d      = sum_q;
		trail_hi_d = trail_hi_q;
		reported_d = reported_q;
		bcount_d   = (bcount_q < spd_pkg::MIN_BUF_BYTES) ? bcount_q + 3'd1 : bcount_q;
		res_valid  = 1'b0;
		res        = '0;

		if (!reported_q) begin
			unique case (phase_q)
				spd_pkg::PH_PAYLOAD: begin
					if (!cur_eob) begin
						res_valid        = 1'b1;
						res.kind         = spd_pkg::KIND_PAYLOAD;
						res.payload_byte = cur_byte;
						res.byte_index   = count_q;
						sum_d            = sum_q + 16'(cur_byte);
						count_d          = count_inc;
						if (count_inc >= total_q) begin
							phase_d = spd_pkg::PH_TRAIL_HI;
						end
					end
				end
				spd_pkg::PH_TRAIL_HI: begin
					trail_hi_d = cur_byte;
					phase_d    = spd_pkg::PH_TRAIL_LO;
				end
				spd_pkg::PH_TRAIL_LO: begin
					res_valid  = 1'b1;
					res.kind   = spd_pkg::KIND_STATUS;
					res.status = ({trail_hi_q, cur_byte} == sum_q) ? spd_pkg::ST_OK
						: spd_pkg::ST_BAD_SUM;
					res.last   = 1'b1;
					reported_d = 1'b1;
				end
				spd_pkg::PH_SEARCH: begin
					if (hdr_hit) begin
						type_d  = window_q[3];
						addr_d  = cur_byte;
						total_d = spd_pkg::length_of_type(window_q[3]);
						count_d = 6'd0;
						sum_d   = 16'(spd_pkg::HDR_S) + 16'(spd_pkg::HDR_N)
							+ 16'(spd_pkg::HDR_P) + 16'(window_q[3]) + 16'(cur_byte);
						phase_d = (spd_pkg::length_of_type(window_q[3]) != 6'd0)
							? spd_pkg::PH_PAYLOAD : spd_pkg::PH_TRAIL_HI;
					end
					window_d[0] = window_q[1];
					window_d[1] = window_q[2];
					window_d[2] = window_q[3];
					window_d[3] = cur_byte;
				end
				default: begin
					phase_d = spd_pkg::PH_SEARCH;
				end
			endcase

			if (cur_eob && !reported_d) begin
				res_valid = 1'b1;
				res.kind  = spd_pkg::KIND_STATUS;
				res.last  = 1'b1;
				priority if (bcount_d < spd_pkg::MIN_BUF_BYTES) begin
					res.status = spd_pkg::ST_TOO_SHORT;
				end else if (phase_d == spd_pkg::PH_SEARCH) begin
					res.status = spd_pkg::ST_NO_HEADER;
				end else begin
					res.status = spd_pkg::ST_INCOMPLETE;
				end
				reported_d = 1'b1;
			end
		end

		// header fields as they stand after this byte
		res.packet_address = addr_d;
		res.packet_type    = type_d;
		res.payload_length = total_d;
		if (!res_valid) begin
			res = '0;
		end

		if (cur_eob) begin
			window_d   = '{default: 8'd0};
			phase_d    = spd_pkg::PH_SEARCH;
			count_d    = 6'd0;
			total_d    = 6'd0;
			type_d     = 8'd0;
			addr_d     = 8'd0;
			sum_d      = 16'd0;
			trail_hi_d = 8'd0;
			bcount_d   = 3'd0;
			reported_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '{default: 8'd0};
			phase_q    <= spd_pkg::PH_SEARCH;
			count_q    <= 6'd0;
			total_q    <= 6'd0;
			type_q     <= 8'd0;
			addr_q     <= 8'd0;
			sum_q      <= 16'd0;
			trail_hi_q <= 8'd0;
			bcount_q   <= 3'd0;
			reported_q <= 1'b0;
		end else if (advance) begin
			window_q   <= window_d;
			phase_q    <= phase_d;
			count_q    <= count_d;
			total_q    <= total_d;
			type_q     <= type_d;
			addr_q     <= addr_d;
			sum_q      <= sum_d;
			trail_hi_q <= trail_hi_d;
			bcount_q   <= bcount_d;
			reported_q <= reported_d;
		end
	end

endmodule

[design/sensor_packet_deframer.sv]
// channel  | dir | beat contents
// ---------+-----+----------------------------------------------------------
// rx       | in  | rx_byte, end_of_buffer
// res      | out | kind, payload_byte, byte_index, status, packet_address,
//          |     | packet_type, payload_length, last
// cfg      | in  | cfg_wr_en / cfg_wr_data -> requested_address
//
// one beat per cycle while res is not stalled; res valid is registered, an accepted rx beat
// passes the input register, then parse logic into the result register
// arst_n clears parser state, the requested address and both valid flags
// a stalled res holds its beat; the input register keeps accepting until it is
// full behind it, so rx.ready drops only while both stages hold data
module sensor_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	spd_rx_if.sink      rx,
	spd_res_if.source   res,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);

	// configured header address, zero accepts any
	logic [7:0]        req_addr_q;

	// input register
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              eob_s1;

	// result register
	logic              res_valid_q;
	spd_pkg::result_t  res_q;

	logic              advance;
	logic              core_valid;
	spd_pkg::result_t  core_res;

	// the stage-one byte moves on when the result register is free or draining
	assign advance  = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_addr_q <= 8'd0;
		end else if (cfg_wr_en) begin
			req_addr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
			eob_s1  <= rx.end_of_buffer;
		end
	end

	// header search, payload count, checksum and status selection
	spd_parse_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (advance),
		.cur_byte          (byte_s1),
		.cur_eob           (eob_s1),
		.requested_address (req_addr_q),
		.res_valid         (core_valid),
		.res               (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= core_valid;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_valid) begin
			res_q <= core_res;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.kind           = res_q.kind;
	assign res.payload_byte   = res_q.payload_byte;
	assign res.byte_index     = res_q.byte_index;
	assign res.status         = res_q.status;
	assign res.packet_address = res_q.packet_address;
	assign res.packet_type    = res_q.packet_type;
	assign res.payload_length = res_q.payload_length;
	assign res.last           = res_q.last;

endmodule
